// File: hw/rtl/pm_pkg.sv
// Shared types for the polynomial multiplier: MAC control bundle.
package pm_pkg;

    // Coefficient and accumulator width
    localparam int unsigned COEF_W = 32;

    // Control from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic vld;   // RAM read data is a term to accumulate
        logic clr;   // start a new product coefficient
    } pm_mac_ctl_t;

endpackage

// File: hw/rtl/polynomial_multiply.sv
// Polynomial multiplier: loads two coefficient runs, streams their convolution.
//
//  channel | dir | tdata              | tuser          | tlast
//  s_axis  | in  | coefficient [31:0] | command (0=P,1=Q) | last of run
//  m_axis  | out | product coef [31:0]| -              | final coefficient
//
// Load transfers append to P or Q. A Q transfer with tlast starts the product:
// each output coefficient k accumulates its terms on the shared multiplier
// (one read per cycle from each coefficient RAM), drains through the RAM read,
// product and accumulator registers, then waits in the output register while
// m_axis_tready is low. An empty P gives a single zero coefficient.
// s_axis_tready is low from the start of the product until its final
// coefficient is taken. Reset clears both counts; the RAMs need no clearing.
module polynomial_multiply
    import pm_pkg::*;
#(
    parameter int unsigned MAX_TERMS = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [COEF_W-1:0] s_axis_tdata,   // [31:0] coefficient
    input  logic              s_axis_tuser,   // [0] command
    input  logic              s_axis_tlast,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [COEF_W-1:0] m_axis_tdata,   // [31:0] product_coefficient
    output logic              m_axis_tlast
);

    localparam int unsigned AW = $clog2(MAX_TERMS);
    localparam int unsigned CW = $clog2(MAX_TERMS + 1);
    localparam int unsigned KW = $clog2(2 * MAX_TERMS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_SEND
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     cnt_p_reg, cnt_p_next;
    logic [CW-1:0]     cnt_q_reg, cnt_q_next;
    logic [CW-1:0]     np_reg, np_next;
    logic [CW-1:0]     nq_reg, nq_next;
    logic [KW-1:0]     k_reg, k_next;
    logic [KW-1:0]     last_k_reg, last_k_next;
    logic [AW-1:0]     i_reg, i_next;
    logic [AW-1:0]     i_hi_reg, i_hi_next;
    logic              rd_vld_reg, rd_vld_next;
    logic              out_vld_reg, out_vld_next;
    logic              out_last_reg, out_last_next;
    logic [COEF_W-1:0] out_data_reg, out_data_next;

    logic              s_xfer;
    logic              p_we, q_we;
    logic [CW-1:0]     nq_start;
    logic [KW-1:0]     k_nx;
    logic [CW-1:0]     np_src, nq_src;
    logic [KW-1:0]     np_m1;
    logic [AW-1:0]     i_lo, i_hi;
    logic [COEF_W-1:0] p_rdata, q_rdata, acc;
    logic              mac_busy;
    pm_mac_ctl_t       mac_ctl;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_xfer        = s_axis_tvalid && s_axis_tready;

    // Appends; a coefficient past the store depth is dropped
    assign p_we     = s_xfer && !s_axis_tuser && (cnt_p_reg < CW'(MAX_TERMS));
    assign q_we     = s_xfer && s_axis_tuser && (cnt_q_reg < CW'(MAX_TERMS));
    assign nq_start = cnt_q_reg + CW'(q_we);

    pm_ram #(.WIDTH(COEF_W), .DEPTH(MAX_TERMS)) u_p_ram (
        .aclk  (aclk),
        .we    (p_we),
        .waddr (cnt_p_reg[AW-1:0]),
        .wdata (s_axis_tdata),
        .raddr (i_reg),
        .rdata (p_rdata)
    );

    pm_ram #(.WIDTH(COEF_W), .DEPTH(MAX_TERMS)) u_q_ram (
        .aclk  (aclk),
        .we    (q_we),
        .waddr (cnt_q_reg[AW-1:0]),
        .wdata (s_axis_tdata),
        .raddr (AW'(k_reg - KW'(i_reg))),
        .rdata (q_rdata)
    );

    pm_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mac_ctl),
        .a       (p_rdata),
        .b       (q_rdata),
        .acc     (acc),
        .busy    (mac_busy)
    );

    // Term range of the next output coefficient: i from i_lo to i_hi
    always_comb begin
        if (state_reg == ST_IDLE) begin
            k_nx   = '0;
            np_src = cnt_p_reg;
            nq_src = nq_start;
        end else begin
            k_nx   = k_reg + KW'(1);
            np_src = np_reg;
            nq_src = nq_reg;
        end
        np_m1 = KW'(np_src) - KW'(1);
        i_lo  = (k_nx >= KW'(nq_src)) ? AW'(k_nx - KW'(nq_src) + KW'(1)) : '0;
        i_hi  = (k_nx > np_m1) ? AW'(np_m1) : AW'(k_nx);
    end

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        cnt_p_next    = cnt_p_reg;
        cnt_q_next    = cnt_q_reg;
        np_next       = np_reg;
        nq_next       = nq_reg;
        k_next        = k_reg;
        last_k_next   = last_k_reg;
        i_next        = i_reg;
        i_hi_next     = i_hi_reg;
        rd_vld_next   = 1'b0;
        out_vld_next  = out_vld_reg;
        out_last_next = out_last_reg;
        out_data_next = out_data_reg;
        mac_ctl.vld   = rd_vld_reg;
        mac_ctl.clr   = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (p_we) begin
                    cnt_p_next = cnt_p_reg + CW'(1);
                end
                if (q_we) begin
                    cnt_q_next = cnt_q_reg + CW'(1);
                end
                if (s_xfer && s_axis_tuser && s_axis_tlast) begin
                    cnt_p_next = '0;
                    cnt_q_next = '0;
                    np_next    = cnt_p_reg;
                    nq_next    = nq_start;
                    k_next     = '0;
                    if (cnt_p_reg == '0) begin
                        // Empty P: a single zero coefficient
                        last_k_next   = '0;
                        out_data_next = '0;
                        out_last_next = 1'b1;
                        out_vld_next  = 1'b1;
                        state_next    = ST_SEND;
                    end else begin
                        last_k_next = KW'(cnt_p_reg) + KW'(nq_start) - KW'(2);
                        i_next      = i_lo;
                        i_hi_next   = i_hi;
                        mac_ctl.clr = 1'b1;
                        state_next  = ST_ISSUE;
                    end
                end
            end
            ST_ISSUE: begin
                rd_vld_next = 1'b1;
                if (i_reg == i_hi_reg) begin
                    state_next = ST_DRAIN;
                end else begin
                    i_next = i_reg + AW'(1);
                end
            end
            ST_DRAIN: begin
                if (!rd_vld_reg && !mac_busy) begin
                    out_data_next = acc;
                    out_last_next = (k_reg == last_k_reg);
                    out_vld_next  = 1'b1;
                    state_next    = ST_SEND;
                end
            end
            ST_SEND: begin
                if (m_axis_tready) begin
                    out_vld_next = 1'b0;
                    if (k_reg == last_k_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        k_next      = k_nx;
                        i_next      = i_lo;
                        i_hi_next   = i_hi;
                        mac_ctl.clr = 1'b1;
                        state_next  = ST_ISSUE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_p_reg   <= '0;
            cnt_q_reg   <= '0;
            rd_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_p_reg   <= cnt_p_next;
            cnt_q_reg   <= cnt_q_next;
            rd_vld_reg  <= rd_vld_next;
            out_vld_reg <= out_vld_next;
        end
        np_reg       <= np_next;
        nq_reg       <= nq_next;
        k_reg        <= k_next;
        last_k_reg   <= last_k_next;
        i_reg        <= i_next;
        i_hi_reg     <= i_hi_next;
        out_last_reg <= out_last_next;
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

// File: hw/rtl/pm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pm_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/pm_mac.sv
// Shared multiply-accumulate unit: registered 32x32 product, wrapping accumulator.
module pm_mac
    import pm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  pm_mac_ctl_t       ctl,
    input  logic [COEF_W-1:0] a,
    input  logic [COEF_W-1:0] b,
    output logic [COEF_W-1:0] acc,
    output logic              busy
);

    logic [COEF_W-1:0]   full_prod;
    logic [COEF_W-1:0]   prod_reg;
    logic                mul_vld_reg;
    logic [COEF_W-1:0]   acc_reg;

    // Product kept to the coefficient width is the wrapped two's complement result
    assign full_prod = a * b;

    // Product stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_vld_reg <= 1'b0;
        end else begin
            mul_vld_reg <= ctl.vld;
        end
        prod_reg <= full_prod;
    end

    // Accumulate stage
    always_ff @(posedge aclk) begin
        if (ctl.clr) begin
            acc_reg <= '0;
        end else if (mul_vld_reg) begin
            acc_reg <= acc_reg + prod_reg;
        end
    end

    assign acc  = acc_reg;
    assign busy = mul_vld_reg;

endmodule

// File: hw/rtl/pm_check.sv
// Port-level checker for the polynomial multiplier, bound to the top level.
module pm_check
    import pm_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic              s_axis_tuser,
    input logic              s_axis_tlast,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [COEF_W-1:0] m_axis_tdata,
    input logic              m_axis_tlast
);

    // No result is offered right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // Input is closed while a result is offered
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while result pending");

    // A Q transfer with tlast starts the product
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser && s_axis_tlast)
        |=> !s_axis_tready)
        else $error("ready after product start");

    // More coefficients follow a non-final result
    a_more_follow: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> !s_axis_tready)
        else $error("input reopened before final coefficient");

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready)
        |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("stalled result changed");

endmodule

bind polynomial_multiply pm_check u_pm_check (.*);
